@@ rtl/itok_pkg.sv @@
// ----------------------------------------------------------------------------
// itok_pkg
// Shared types and constants for the input line tokenizer.
// ----------------------------------------------------------------------------
package itok_pkg;

    // result kinds
    localparam logic [1:0] KIND_STORED    = 2'd0;
    localparam logic [1:0] KIND_DROPPED   = 2'd1;
    localparam logic [1:0] KIND_LINE_DONE = 2'd2;

    // configuration register indexes
    localparam int          CFG_IDX_W          = 3;
    localparam int          CFG_DATA_W         = 64;
    localparam logic [2:0]  REG_TEXT_START     = 3'd0;
    localparam logic [2:0]  REG_MAX_TOKENS     = 3'd1;
    localparam logic [2:0]  REG_PUNCT_COUNT    = 3'd2;
    localparam logic [2:0]  REG_PUNCT_LOW      = 3'd3;
    localparam logic [2:0]  REG_PUNCT_HIGH     = 3'd4;

    // fixed separators: space, tab, newline, formfeed, period, comma, question mark
    localparam int NUM_SEPS = 7;
    localparam logic [NUM_SEPS-1:0][7:0] SEP_CHARS = {
        8'h3F, 8'h2C, 8'h2E, 8'h0C, 8'h0A, 8'h09, 8'h20
    };

    // queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = 2;
    localparam int QUEUE_CNT_W = 3;

    // most results one request can cause
    localparam int MAX_RESULTS = 3;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] slot;
        logic [8:0] start;
        logic [7:0] length;
        logic [7:0] wcount;
    } itok_rec_t;

    typedef struct packed {
        itok_rec_t [MAX_RESULTS-1:0] recs;
        logic [1:0]                  count;
    } itok_entry_t;

endpackage

@@ rtl/itok_front.sv @@
// ----------------------------------------------------------------------------
// itok_front
// Holds configuration and line state, classifies each character and builds
// the full set of results for one request combinationally.
// ----------------------------------------------------------------------------
module itok_front
    import itok_pkg::*;
#(
    parameter int MAX_PUNCT = 15
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [7:0]            ch,
    input  logic                  has_char,
    input  logic                  line_end,
    input  logic                  q_full,
    output logic                  q_push,
    output itok_entry_t           q_data
);

    localparam logic [3:0] PUNCT_LIM = 4'(MAX_PUNCT);

    logic [1:0]                      text_start_reg;
    logic [7:0]                      max_tokens_reg;
    logic [3:0]                      punct_count_reg;
    logic [MAX_PUNCT-1:0][7:0]       punct_reg;

    logic       in_word_reg,      in_word_next;
    logic [7:0] word_start_reg,   word_start_next;
    logic [7:0] word_length_reg,  word_length_next;
    logic [7:0] char_index_reg,   char_index_next;
    logic [7:0] stored_count_reg, stored_count_next;

    logic       accept;
    logic       is_punct;
    logic       is_sep;
    logic [3:0] punct_lim;
    logic       list_alive;
    itok_entry_t entry;

    // build one token result
    function automatic itok_rec_t tok_rec(
        input logic [7:0] sc,
        input logic       stored,
        input logic [1:0] ts,
        input logic [7:0] sidx,
        input logic [7:0] len
    );
        itok_rec_t r;
        r.kind   = stored ? KIND_STORED : KIND_DROPPED;
        r.slot   = stored ? sc : 8'd0;
        r.start  = 9'(ts) + 9'(sidx);
        r.length = len;
        r.wcount = stored ? sc + 8'd1 : sc;
        return r;
    endfunction

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            text_start_reg  <= 2'd1;
            max_tokens_reg  <= 8'd255;
            punct_count_reg <= 4'd0;
            punct_reg       <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_TEXT_START:  text_start_reg  <= cfg_data[1:0];
                REG_MAX_TOKENS:  max_tokens_reg  <= cfg_data[7:0];
                REG_PUNCT_COUNT: punct_count_reg <= cfg_data[3:0];
                REG_PUNCT_LOW:
                begin
                    for (int i = 0; i < MAX_PUNCT; i++)
                    begin
                        if (i < 8)
                        begin
                            punct_reg[i] <= cfg_data[8*(i%8) +: 8];
                        end
                    end
                end
                REG_PUNCT_HIGH:
                begin
                    for (int i = 0; i < MAX_PUNCT; i++)
                    begin
                        if (i >= 8)
                        begin
                            punct_reg[i] <= cfg_data[8*(i%8) +: 8];
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // punctuation match, list ends at the first zero entry
    always_comb
    begin
        punct_lim  = (punct_count_reg > PUNCT_LIM) ? PUNCT_LIM : punct_count_reg;
        list_alive = 1'b1;
        is_punct   = 1'b0;
        for (int i = 0; i < MAX_PUNCT; i++)
        begin
            if (4'(i) < punct_lim && list_alive)
            begin
                if (punct_reg[i] == 8'd0)
                begin
                    list_alive = 1'b0;
                end
                else if (punct_reg[i] == ch)
                begin
                    is_punct = 1'b1;
                end
            end
        end
    end

    // fixed separator match
    always_comb
    begin
        is_sep = 1'b0;
        for (int i = 0; i < NUM_SEPS; i++)
        begin
            if (SEP_CHARS[i] == ch)
            begin
                is_sep = 1'b1;
            end
        end
    end

    // word state update and result building
    always_comb
    begin
        logic [7:0] sc;
        logic [7:0] idx;
        logic [1:0] n;
        logic       stored;

        sc     = stored_count_reg;
        idx    = char_index_reg;
        n      = 2'd0;
        stored = 1'b0;

        in_word_next     = in_word_reg;
        word_start_next  = word_start_reg;
        word_length_next = word_length_reg;
        char_index_next  = char_index_reg;
        entry            = '0;

        if (has_char)
        begin
            char_index_next = char_index_reg + 8'd1;
            if (is_punct || is_sep)
            begin
                // pending word ends first
                if (in_word_reg)
                begin
                    stored               = sc < max_tokens_reg;
                    entry.recs[0]        = tok_rec(sc, stored, text_start_reg,
                                                   word_start_reg, word_length_reg);
                    sc                   = stored ? sc + 8'd1 : sc;
                    n                    = 2'd1;
                    in_word_next         = 1'b0;
                end
                if (is_punct)
                begin
                    stored               = sc < max_tokens_reg;
                    entry.recs[n]        = tok_rec(sc, stored, text_start_reg,
                                                   idx, 8'd1);
                    sc                   = stored ? sc + 8'd1 : sc;
                    n                    = n + 2'd1;
                end
            end
            else if (!in_word_reg)
            begin
                in_word_next     = 1'b1;
                word_start_next  = idx;
                word_length_next = 8'd1;
            end
            else if (word_length_reg != 8'd255)
            begin
                word_length_next = word_length_reg + 8'd1;
            end
        end

        if (line_end)
        begin
            // flush pending word, then report the line
            if (in_word_next)
            begin
                stored        = sc < max_tokens_reg;
                entry.recs[n] = tok_rec(sc, stored, text_start_reg,
                                        word_start_next, word_length_next);
                sc            = stored ? sc + 8'd1 : sc;
                n             = n + 2'd1;
            end
            entry.recs[n].kind   = KIND_LINE_DONE;
            entry.recs[n].slot   = 8'd0;
            entry.recs[n].start  = 9'd0;
            entry.recs[n].length = 8'd0;
            entry.recs[n].wcount = sc;
            n                    = n + 2'd1;
            in_word_next         = 1'b0;
            word_start_next      = 8'd0;
            word_length_next     = 8'd0;
            char_index_next      = 8'd0;
            sc                   = 8'd0;
        end

        stored_count_next = sc;
        entry.count       = n;
    end

    assign q_push = accept && (entry.count != 2'd0);
    assign q_data = entry;

    // line state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_word_reg      <= 1'b0;
            word_start_reg   <= 8'd0;
            word_length_reg  <= 8'd0;
            char_index_reg   <= 8'd0;
            stored_count_reg <= 8'd0;
        end
        else if (accept)
        begin
            in_word_reg      <= in_word_next;
            word_start_reg   <= word_start_next;
            word_length_reg  <= word_length_next;
            char_index_reg   <= char_index_next;
            stored_count_reg <= stored_count_next;
        end
    end

endmodule

@@ rtl/itok_queue.sv @@
// ----------------------------------------------------------------------------
// itok_queue
// Short queue of result groups between the front and the back.
// ----------------------------------------------------------------------------
module itok_queue
    import itok_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  itok_entry_t push_data,
    output logic        full,
    input  logic        pop,
    output logic        empty,
    output itok_entry_t head
);

    itok_entry_t             entry_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0]  wr_ptr_reg;
    logic [QUEUE_PTR_W-1:0]  rd_ptr_reg;
    logic [QUEUE_CNT_W-1:0]  count_reg;
    logic                    do_push;
    logic                    do_pop;

    assign full    = (count_reg == QUEUE_CNT_W'(QUEUE_DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head    = entry_reg[rd_ptr_reg];

    // storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + QUEUE_PTR_W'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + QUEUE_PTR_W'(1);
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + QUEUE_CNT_W'(1);
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - QUEUE_CNT_W'(1);
            end
        end
    end

endmodule

@@ rtl/itok_back.sv @@
// ----------------------------------------------------------------------------
// itok_back
// Walks through the results of each queued group and drives them one per
// cycle from an output register while the receiver keeps out_ready high.
// ----------------------------------------------------------------------------
module itok_back
    import itok_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        q_empty,
    input  itok_entry_t q_head,
    output logic        q_pop,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  kind,
    output logic [7:0]  token_slot,
    output logic [8:0]  token_start,
    output logic [7:0]  token_size,
    output logic [7:0]  word_count,
    output logic        last
);

    logic        out_valid_reg;
    itok_rec_t   rec_reg;
    logic        last_reg;
    logic [1:0]  sub_reg;
    logic        load;
    logic        final_rec;

    assign load      = !q_empty && (!out_valid_reg || out_ready);
    assign final_rec = (sub_reg == q_head.count - 2'd1);
    assign q_pop     = load && final_rec;

    // result index within the current group
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sub_reg       <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                out_valid_reg <= 1'b1;
                sub_reg       <= final_rec ? 2'd0 : sub_reg + 2'd1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // output payload
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            rec_reg  <= q_head.recs[sub_reg];
            last_reg <= final_rec;
        end
    end

    assign out_valid    = out_valid_reg;
    assign kind         = rec_reg.kind;
    assign token_slot   = rec_reg.slot;
    assign token_start  = rec_reg.start;
    assign token_size   = rec_reg.length;
    assign word_count   = rec_reg.wcount;
    assign last         = last_reg;

endmodule

@@ rtl/input_line_tokenizer.sv @@
// ----------------------------------------------------------------------------
// input_line_tokenizer
// Splits a typed line, one character per request, into tokens.
//
// Input channel (in_valid/in_ready): ch, has_char, line_end. A request with
// has_char low and line_end low does nothing and gives no result.
// Output channel (out_valid/out_ready): one result per request moved, with
// last high on the final result caused by an input request (up to three).
// Config port: cfg_we, cfg_index, cfg_data; to be written only while idle, which the block does not enforce.
//
// The group of a request is written into the queue when the request is
// accepted; the back then loads its first result into the output register
// once no older group is waiting and the output register is free or taken.
// Throughput: one input request per cycle while the queue is not full and
// one result per cycle while out_ready is high; the output register sets the
// result rate: a request giving two or three results sends them one by one.
// A four-group queue parts front and back; in_ready drops only while that
// queue is full, which happens when the receiver stalls out_ready or when
// requests giving several results each arrive back to back.
// Reset clears line state, the queue and the output valid flag, and puts the
// configuration back to text_start 1, max_tokens 255, no punctuation.
// ----------------------------------------------------------------------------
module input_line_tokenizer
    import itok_pkg::*;
#(
    parameter int MAX_PUNCT = 15
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [7:0]            ch,
    input  logic                  has_char,
    input  logic                  line_end,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [1:0]            kind,
    output logic [7:0]            token_slot,
    output logic [8:0]            token_start,
    output logic [7:0]            token_size,
    output logic [7:0]            word_count,
    output logic                  last
);

    logic        q_full;
    logic        q_push;
    itok_entry_t q_data;
    logic        q_pop;
    logic        q_empty;
    itok_entry_t q_head;

    // classification and line state
    itok_front #(
        .MAX_PUNCT (MAX_PUNCT)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .ch        (ch),
        .has_char  (has_char),
        .line_end  (line_end),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_data    (q_data)
    );

    // result group queue
    itok_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_data),
        .full      (q_full),
        .pop       (q_pop),
        .empty     (q_empty),
        .head      (q_head)
    );

    // result sequencing and output register
    itok_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_empty      (q_empty),
        .q_head       (q_head),
        .q_pop        (q_pop),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .kind         (kind),
        .token_slot   (token_slot),
        .token_start  (token_start),
        .token_size   (token_size),
        .word_count   (word_count),
        .last         (last)
    );

endmodule

@@ rtl/itok_checker.sv @@
// ----------------------------------------------------------------------------
// itok_checker
// Port-level checks on the tokenizer's result stream.
// ----------------------------------------------------------------------------
module itok_checker
    import itok_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  out_valid,
    input logic                  out_ready,
    input logic [1:0]            kind,
    input logic [7:0]            token_slot,
    input logic [8:0]            token_start,
    input logic [7:0]            token_size,
    input logic [7:0]            word_count,
    input logic                  last
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(kind) && $stable(word_count)
            && $stable(token_start) && $stable(last))
        else $error("stalled result changed");

    // line finished is always the final result of its request
    a_line_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind == KIND_LINE_DONE |-> last && token_start == 9'd0
            && token_size == 8'd0 && token_slot == 8'd0)
        else $error("line finished result malformed");

    // a stored token's count includes itself
    a_slot_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind == KIND_STORED |-> word_count == token_slot + 8'd1)
        else $error("stored slot and word count disagree");

    // dropped tokens carry no slot
    a_drop_slot: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind == KIND_DROPPED |-> token_slot == 8'd0 && token_size != 8'd0)
        else $error("dropped token malformed");

endmodule

bind input_line_tokenizer itok_checker u_itok_checker (.*);

@@ verif/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Checks input_line_tokenizer against a cycle-free model of its token
// rules kept inside this bench. Directed lines cover the separators, the
// punctuation list and its zero stop, and the token limit. Random lines
// under random configurations follow. Both channels stall at random,
// and the result channel is held off once for a long stretch so the block
// fills up and stalls its input.
// ----------------------------------------------------------------------------
module tb
    import itok_pkg::*;
();

    localparam int MAX_PUNCT    = 15;
    localparam int DRAIN_CYCLES = 8;
    localparam int HOLD_CYCLES  = 60;

    // characters used by the directed lines
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_FF    = 8'h0C;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_QUERY = 8'h3F;
    localparam logic [7:0] CH_BANG  = 8'h21;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_ALL1  = 8'hFF;

    localparam logic [6:0][7:0] WORD_BREAKS = {
        CH_QUERY, CH_COMMA, CH_DOT, CH_FF, CH_NL, CH_TAB, CH_SPACE
    };

    typedef struct {
        logic [1:0] kind;
        logic [7:0] slot;
        logic [8:0] start;
        logic [7:0] length;
        logic [7:0] wcount;
        logic       last;
    } token_result_t;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    logic                  in_valid  = 1'b0;
    logic                  in_ready;
    logic [7:0]            ch        = 8'h00;
    logic                  has_char  = 1'b0;
    logic                  line_end  = 1'b0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic [1:0]            kind;
    logic [7:0]            token_slot;
    logic [8:0]            token_start;
    logic [7:0]            token_size;
    logic [7:0]            word_count;
    logic                  last;

    // tokens still to come out of the block, oldest first
    token_result_t pending_tokens[$];
    int            mismatch_count = 0;

    // stall control shared by the sender and the receiver
    bit tx_gaps   = 1'b1;
    bit rx_stalls = 1'b1;
    bit hold_rx   = 1'b0;

    // configuration as the bench believes it to be
    logic [1:0]  cf_text_start  = 2'd1;
    logic [7:0]  cf_max_tokens  = 8'd255;
    logic [3:0]  cf_punct_count = 4'd0;
    logic [63:0] cf_punct_low   = '0;
    logic [55:0] cf_punct_high  = '0;

    // line state of the tokenizer
    bit         tk_in_word   = 1'b0;
    logic [7:0] tk_word_pos  = '0;
    logic [7:0] tk_word_len  = '0;
    logic [7:0] tk_char_pos  = '0;
    logic [7:0] tk_stored    = '0;

    input_line_tokenizer uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .ch           (ch),
        .has_char     (has_char),
        .line_end     (line_end),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .kind         (kind),
        .token_slot   (token_slot),
        .token_start  (token_start),
        .token_size   (token_size),
        .word_count   (word_count),
        .last         (last)
    );

    always #6 clk = ~clk;

    // ------------------------------------------------------------------
    // token rules
    // ------------------------------------------------------------------
    function automatic logic [7:0] punct_entry(input int i);
        if (i < 8)
            return cf_punct_low[8*i +: 8];
        return cf_punct_high[8*(i-8) +: 8];
    endfunction

    function automatic int punct_in_use();
        int n;
        n = (cf_punct_count > MAX_PUNCT) ? MAX_PUNCT : cf_punct_count;
        // a zero entry cuts the list short
        for (int i = 0; i < n; i++)
        begin
            if (punct_entry(i) == 8'h00)
                return i;
        end
        return n;
    endfunction

    function automatic bit is_punct_char(input logic [7:0] c);
        int n;
        n = punct_in_use();
        for (int i = 0; i < n; i++)
        begin
            if (punct_entry(i) == c)
                return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic bit is_word_break(input logic [7:0] c);
        for (int i = 0; i < 7; i++)
        begin
            if (WORD_BREAKS[i] == c)
                return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic void push_token(input logic [1:0] k, input logic [7:0] slot,
                                       input logic [8:0] start, input logic [7:0] len);
        token_result_t r;
        r.kind   = k;
        r.slot   = slot;
        r.start  = start;
        r.length = len;
        r.wcount = tk_stored;
        r.last   = 1'b0;
        pending_tokens.push_back(r);
    endfunction

    // store a token in the next slot, or report it dropped once the table is full
    function automatic void take_token(input logic [7:0] pos, input logic [7:0] len);
        logic [8:0] start;
        start = {7'd0, cf_text_start} + {1'b0, pos};
        if (tk_stored < cf_max_tokens)
        begin
            tk_stored = tk_stored + 8'd1;
            push_token(KIND_STORED, tk_stored - 8'd1, start, len);
        end
        else
        begin
            push_token(KIND_DROPPED, 8'd0, start, len);
        end
    endfunction

    function automatic void tokenize_char(input logic [7:0] c, input bit has, input bit fin);
        int         before_cnt;
        logic [7:0] pos;
        before_cnt = pending_tokens.size();
        if (has)
        begin
            pos = tk_char_pos;
            tk_char_pos = tk_char_pos + 8'd1;
            if (is_punct_char(c))
            begin
                if (tk_in_word)
                    take_token(tk_word_pos, tk_word_len);
                tk_in_word = 1'b0;
                take_token(pos, 8'd1);
            end
            else if (is_word_break(c))
            begin
                if (tk_in_word)
                    take_token(tk_word_pos, tk_word_len);
                tk_in_word = 1'b0;
            end
            else if (!tk_in_word)
            begin
                tk_in_word  = 1'b1;
                tk_word_pos = pos;
                tk_word_len = 8'd1;
            end
            else if (tk_word_len != 8'd255)
            begin
                tk_word_len = tk_word_len + 8'd1;
            end
        end
        // line end flushes the word, reports the count and starts over
        if (fin)
        begin
            if (tk_in_word)
                take_token(tk_word_pos, tk_word_len);
            push_token(KIND_LINE_DONE, 8'd0, 9'd0, 8'd0);
            tk_in_word  = 1'b0;
            tk_word_pos = '0;
            tk_word_len = '0;
            tk_char_pos = '0;
            tk_stored   = '0;
        end
        if (pending_tokens.size() > before_cnt)
            pending_tokens[pending_tokens.size()-1].last = 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // result checking
    // ------------------------------------------------------------------
    function automatic void check_field(input string name, input logic [8:0] want,
                                        input logic [8:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatch_count++;
        end
    endfunction

    always @(posedge clk)
    begin
        token_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_tokens.size() == 0)
            begin
                $error("unexpected result: kind %0d start %0d length %0d",
                       kind, token_start, token_size);
                mismatch_count++;
            end
            else
            begin
                want = pending_tokens.pop_front();
                check_field("kind", want.kind, kind);
                check_field("token_slot", want.slot, token_slot);
                check_field("token_start", want.start, token_start);
                check_field("token_size", want.length, token_size);
                check_field("word_count", want.wcount, word_count);
                check_field("last", want.last, last);
            end
        end
    end

    // ------------------------------------------------------------------
    // receiver: random stalls, one long hold on request
    // ------------------------------------------------------------------
    initial
    begin
        int n;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_rx)
            begin
                hold_rx = 1'b0;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge clk);
            end
            else if (rx_stalls && $urandom_range(0, 3) == 0)
            begin
                n = $urandom_range(1, 19);
                out_ready <= 1'b0;
                repeat (n - 1) @(negedge clk);
            end
            else
            begin
                n = rx_stalls ? $urandom_range(1, 30) : 1;
                out_ready <= 1'b1;
                repeat (n - 1) @(negedge clk);
            end
        end
    end

    // ------------------------------------------------------------------
    // sender and configuration
    // ------------------------------------------------------------------
    task automatic send_item(input logic [7:0] c, input bit has, input bit fin);
        int gap;
        if (tx_gaps && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 19);
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        in_valid <= 1'b1;
        ch       <= c;
        has_char <= has;
        line_end <= fin;
        do
            @(posedge clk);
        while (!in_ready);
        tokenize_char(c, has, fin);
    endtask

    task automatic send_text(input string s, input bit fin);
        for (int i = 0; i < s.len(); i++)
            send_item(s[i], 1'b1, fin && (i == s.len() - 1));
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] data);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge clk);
        cfg_we    <= 1'b0;
        case (idx)
            REG_TEXT_START:  cf_text_start  = data[1:0];
            REG_MAX_TOKENS:  cf_max_tokens  = data[7:0];
            REG_PUNCT_COUNT: cf_punct_count = data[3:0];
            REG_PUNCT_LOW:   cf_punct_low   = data;
            REG_PUNCT_HIGH:  cf_punct_high  = data[55:0];
            default: ;
        endcase
    endtask

    // let every pending token come out, then let the pipeline settle
    task automatic wait_idle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_tokens.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------
    task automatic test_reset_defaults();
        // no punctuation yet, so '!' is part of the word
        send_text("hi! go", 1'b1);
        send_item(CH_BANG, 1'b0, 1'b1);
    endtask

    task automatic test_separators();
        wait_idle();
        write_reg(REG_TEXT_START, 64'd2);
        write_reg(REG_PUNCT_COUNT, 64'd4);
        write_reg(REG_PUNCT_LOW, {32'h0000_0000, CH_DOT, CH_ALL1, CH_SEMI, CH_BANG});
        write_reg(REG_PUNCT_HIGH, 64'd0);
        // punctuation right after a word, then a period that is punctuation here
        send_text("ab!", 1'b0);
        send_item(CH_SPACE, 1'b1, 1'b0);
        send_item(8'h63, 1'b1, 1'b0);
        send_item(CH_NUL, 1'b1, 1'b0);
        send_item(CH_DOT, 1'b1, 1'b0);
        send_item(CH_ALL1, 1'b1, 1'b0);
        send_item(CH_SEMI, 1'b1, 1'b0);
        // every fixed separator, some between words
        send_item(CH_TAB, 1'b1, 1'b0);
        send_item(8'h64, 1'b1, 1'b0);
        send_item(CH_NL, 1'b1, 1'b0);
        send_item(CH_FF, 1'b1, 1'b0);
        send_item(8'h65, 1'b1, 1'b0);
        send_item(CH_COMMA, 1'b1, 1'b0);
        send_item(CH_QUERY, 1'b1, 1'b0);
        // an empty request inside a word leaves it open
        send_item(8'h78, 1'b1, 1'b0);
        send_item(CH_ALL1, 1'b0, 1'b0);
        send_item(8'h7F, 1'b1, 1'b1);
        // end-only request on an empty line
        send_item(8'h80, 1'b0, 1'b1);
    endtask

    task automatic test_punct_list();
        wait_idle();
        write_reg(REG_TEXT_START, 64'd1);
        write_reg(REG_PUNCT_COUNT, 64'd15);
        write_reg(REG_PUNCT_LOW, 64'h2A29_2826_2524_2321);
        // upper byte is outside the register; entry 12 is zero and stops the list
        write_reg(REG_PUNCT_HIGH, 64'hA53E_3C00_3A2F_2D2B);
        send_text("!w+/x:<y>z", 1'b0);
        send_item(CH_NUL, 1'b1, 1'b0);
        send_item(CH_SPACE, 1'b1, 1'b1);
        // short list: only the first two entries count
        wait_idle();
        write_reg(REG_PUNCT_COUNT, 64'd2);
        send_text("a#b!c$", 1'b1);
    endtask

    task automatic test_token_limit();
        wait_idle();
        write_reg(REG_MAX_TOKENS, 64'd0);
        write_reg(REG_PUNCT_COUNT, 64'd1);
        send_text("ab cd!", 1'b1);
        wait_idle();
        write_reg(REG_MAX_TOKENS, 64'd2);
        send_text("a b c d", 1'b1);
        wait_idle();
        write_reg(REG_MAX_TOKENS, 64'd1);
        send_text("!q", 1'b1);
    endtask

    task automatic test_backpressure();
        wait_idle();
        write_reg(REG_PUNCT_COUNT, 64'd1);
        write_reg(REG_PUNCT_LOW, {56'd0, CH_BANG});
        tx_gaps = 1'b0;
        hold_rx = 1'b1;
        // start sending once the receiver has begun its hold
        wait (hold_rx == 1'b0);
        // steady requests while the receiver holds off
        for (int i = 0; i < 30; i++)
            send_item((i % 3 == 2) ? 8'h6B : CH_BANG, 1'b1, i == 29);
        tx_gaps = 1'b1;
    endtask

    function automatic logic [7:0] pick_punct();
        int n;
        n = punct_in_use();
        if (n == 0)
            return CH_BANG;
        return punct_entry($urandom_range(0, n - 1));
    endfunction

    task automatic random_config();
        logic [7:0]  mt;
        logic [63:0] plow;
        case ($urandom_range(0, 4))
            0: mt = 8'd0;
            1: mt = 8'd255;
            2: mt = 8'($urandom_range(1, 4));
            default: mt = 8'($urandom);
        endcase
        plow = {$urandom, $urandom};
        if ($urandom_range(0, 3) == 0)
            plow[8*$urandom_range(0, 7) +: 8] = 8'h00;
        wait_idle();
        write_reg(REG_TEXT_START, {$urandom, $urandom});
        write_reg(REG_MAX_TOKENS, {32'($urandom), 24'($urandom), mt});
        write_reg(REG_PUNCT_COUNT, 64'($urandom_range(0, 15)));
        write_reg(REG_PUNCT_LOW, plow);
        write_reg(REG_PUNCT_HIGH, {$urandom, $urandom});
    endtask

    // mostly words split by separators and punctuation, some noise
    task automatic send_random_lines(input int n_items);
        int         sent;
        int         len;
        int         pick;
        bit         end_on_char;
        logic [7:0] c;
        sent = 0;
        while (sent < n_items)
        begin
            len = $urandom_range(1, 24);
            end_on_char = $urandom_range(0, 1);
            for (int i = 0; i < len; i++)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 3)
                begin
                    send_item(8'($urandom), 1'b0, 1'b0);
                    continue;
                end
                if (pick < 55)
                    c = 8'h61 + 8'($urandom_range(0, 25));
                else if (pick < 75)
                    c = WORD_BREAKS[$urandom_range(0, 6)];
                else if (pick < 88)
                    c = pick_punct();
                else
                    c = 8'($urandom);
                send_item(c, 1'b1, end_on_char && (i == len - 1));
                sent++;
            end
            // a few lines run on without an end marker
            if (!end_on_char && $urandom_range(0, 9) != 0)
            begin
                send_item(8'($urandom), 1'b0, 1'b1);
                sent++;
            end
        end
    endtask

    task automatic test_random();
        for (int phase = 0; phase < 4; phase++)
        begin
            random_config();
            if (phase == 3)
            begin
                tx_gaps   = 1'b0;
                rx_stalls = 1'b0;
            end
            send_random_lines(16);
        end
    endtask

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial
    begin
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;
        test_reset_defaults();
        test_separators();
        test_punct_list();
        test_token_limit();
        test_backpressure();
        test_random();
        wait_idle();
        if (mismatch_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // watchdog
    initial
    begin
        #20_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
